FILE: sv/jlrm_pkg.sv
package jlrm_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;

	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MARGIN       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSLATION_MARGIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_RATIO     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_RATE         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_POSITION     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_VELOCITY     = 3'd5;

	localparam logic [1:0] KIND_ROTATIONAL = 2'd0;
	localparam logic [1:0] KIND_SLIDING    = 2'd1;

	// output queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [5:0]         joint_index;
		logic signed [31:0] position;
		logic signed [31:0] lower_limit;
		logic signed [31:0] upper_limit;
		logic signed [31:0] lower_velocity_limit;
		logic signed [31:0] upper_velocity_limit;
		logic [1:0]         joint_kind;
		logic               selected;
		logic               first_frame;
		logic               last_frame;
	} sample_t;

	typedef struct packed {
		logic [5:0]         joint_out;
		logic               position_fault;
		logic               position_fault_start;
		logic               prior_velocity_valid;
		logic signed [31:0] prior_velocity;
		logic               prior_velocity_fault_start;
		logic signed [31:0] final_velocity;
		logic               final_velocity_fault_start;
	} result_t;

	// per-joint position history and position run bit
	typedef struct packed {
		logic [31:0] p1;
		logic [31:0] p2;
		logic        prev_first;
		logic        pos_fault;
	} pos_state_t;

	typedef struct packed {
		logic [5:0] joint;
		logic       pos_fault;
		logic       pos_start;
		logic       first_frame;
		logic       last_frame;
		logic       vchk;
	} ctl_t;

	// floor(num / 2), clamped to the signed 32-bit range
	function automatic logic [31:0] sat_half(input logic signed [43:0] num);
		logic signed [43:0] h;
		h = num >>> 1;
		if (h > 44'sd2147483647) begin
			return 32'h7fff_ffff;
		end else if (h < -44'sd2147483648) begin
			return 32'h8000_0000;
		end else begin
			return h[31:0];
		end
	endfunction

endpackage

FILE: sv/jlrm_stream_if.sv
interface jlrm_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: sv/joint_limit_run_monitor_unit.sv
// Path: a word accepted on the input passes the stage registers and is then pushed into
//   the result queue, from which it is offered on the result channel.
// Throughput: one word per cycle while input ready holds, any joint order, same joint back to back;
//   set by the per-joint read-modify-write of the two state memories, bridged by forwarding.
// Input ready drops only when 8 words are in flight or queued (output stalled).
// Reset (arst_n, async low): config back to defaults, pipeline, queue and the per-joint
//   valid bits cleared at once; no clearing pass, position history is undefined until written.
module joint_limit_run_monitor_unit #(
	parameter int JOINTS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [jlrm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jlrm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	jlrm_stream_if.sink                     sample,
	jlrm_stream_if.source                   result
);

	localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [17:0] angle_q;
	logic signed [20:0] trans_q;
	logic [6:0]         ratio_q;
	logic [9:0]         rate_q;
	logic               chk_pos_q;
	logic               chk_vel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q   <= '0;
			trans_q   <= '0;
			ratio_q   <= 7'd100;
			rate_q    <= 10'd100;
			chk_pos_q <= 1'b1;
			chk_vel_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				jlrm_pkg::REG_ANGLE_MARGIN:       angle_q   <= cfg_wdata[17:0];
				jlrm_pkg::REG_TRANSLATION_MARGIN: trans_q   <= cfg_wdata[20:0];
				jlrm_pkg::REG_VELOCITY_RATIO:     ratio_q   <= cfg_wdata[6:0];
				jlrm_pkg::REG_FRAME_RATE:         rate_q    <= cfg_wdata[9:0];
				jlrm_pkg::REG_CHECK_POSITION:     chk_pos_q <= cfg_wdata[0];
				jlrm_pkg::REG_CHECK_VELOCITY:     chk_vel_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Credit: words accepted and not yet taken on the result side.
	// Queue depth covers the whole pipeline, so the pipeline never stalls.
	// ------------------------------------------------------------------
	logic                       take, pop;
	logic [jlrm_pkg::OCC_W-1:0] occ_q;

	assign sample.ready = (occ_q < jlrm_pkg::OCC_W'(jlrm_pkg::FIFO_DEPTH));
	assign take         = sample.valid && sample.ready;
	assign pop          = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			case ({take, pop})
				2'b10:   occ_q <= occ_q + 1'b1;
				2'b01:   occ_q <= occ_q - 1'b1;
				default: occ_q <= occ_q;
			endcase
		end
	end

	// joint index folded onto the state depth (small table, 64 entries)
	function automatic logic [AW-1:0] joint_slot(input logic [5:0] ji);
		logic [AW-1:0] r;
		r = '0;
		for (int k = 0; k < 64; k++) begin
			if (ji == 6'(k)) begin
				r = AW'(k % JOINTS);
			end
		end
		return r;
	endfunction

	logic [AW-1:0] slot_in;
	assign slot_in = joint_slot(sample.data.joint_index);

	// ------------------------------------------------------------------
	// Stage 1: position state read back, position check, differences.
	// Memory A holds p1/p2/prev_first/position run bit; written here.
	// ------------------------------------------------------------------
	jlrm_pkg::pos_state_t mem_a [JOINTS];
	logic [JOINTS-1:0]    vld_a_q;

	logic                 v_s1;
	jlrm_pkg::sample_t    smp_s1;
	logic [AW-1:0]        slot_s1;
	jlrm_pkg::pos_state_t rd_a_s1;
	logic                 rdv_a_s1;

	logic                 v_s2;
	logic [AW-1:0]        slot_s2;
	jlrm_pkg::pos_state_t wr_a_s2;

	jlrm_pkg::pos_state_t cur_a, wr_a;
	logic signed [32:0]   q33, ul33, ll33, p1_33, prev_33, margin, pos_hi, pos_lo;
	logic signed [32:0]   d1, d2;
	logic                 pfault, pfl_old, pstart, pos_kind;
	jlrm_pkg::ctl_t       ctl_s1;

	always_ff @(posedge clk) begin
		if (take) begin
			smp_s1  <= sample.data;
			slot_s1 <= slot_in;
			rd_a_s1 <= mem_a[slot_in];
		end
		if (v_s1) begin
			mem_a[slot_s1] <= wr_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			rdv_a_s1 <= 1'b0;
			vld_a_q  <= '0;
		end else begin
			v_s1 <= take;
			if (take) begin
				rdv_a_s1 <= vld_a_q[slot_in];
			end
			if (v_s1) begin
				vld_a_q[slot_s1] <= 1'b1;
			end
		end
	end

	always_comb begin
		// the word one ahead wrote on the edge of our read: take its copy
		if (v_s2 && (slot_s2 == slot_s1)) begin
			cur_a = wr_a_s2;
		end else if (rdv_a_s1) begin
			cur_a = rd_a_s1;
		end else begin
			cur_a = '0;
		end

		q33   = {smp_s1.position[31], smp_s1.position};
		ul33  = {smp_s1.upper_limit[31], smp_s1.upper_limit};
		ll33  = {smp_s1.lower_limit[31], smp_s1.lower_limit};
		p1_33 = {cur_a.p1[31], cur_a.p1};

		if (smp_s1.joint_kind == jlrm_pkg::KIND_ROTATIONAL) begin
			margin = {{15{angle_q[17]}}, angle_q};
		end else begin
			margin = {{12{trans_q[20]}}, trans_q};
		end
		pos_kind = (smp_s1.joint_kind == jlrm_pkg::KIND_ROTATIONAL) ||
		           (smp_s1.joint_kind == jlrm_pkg::KIND_SLIDING);
		pos_hi   = ul33 - margin;
		pos_lo   = ll33 + margin;
		pfault   = smp_s1.selected && chk_pos_q && pos_kind &&
		           ((q33 > pos_hi) || (q33 < pos_lo));
		pfl_old  = smp_s1.first_frame ? 1'b0 : cur_a.pos_fault;
		pstart   = pfault && !pfl_old;

		// prior frame: next minus previous, previous is the frame itself after a first frame
		prev_33 = cur_a.prev_first ? p1_33 : {cur_a.p2[31], cur_a.p2};
		d1      = q33 - prev_33;
		d2      = smp_s1.first_frame ? 33'sd0 : (q33 - p1_33);

		wr_a.p1         = smp_s1.position;
		wr_a.p2         = cur_a.p1;
		wr_a.prev_first = smp_s1.first_frame;
		wr_a.pos_fault  = pfault;

		ctl_s1.joint       = smp_s1.joint_index;
		ctl_s1.pos_fault   = pfault;
		ctl_s1.pos_start   = pstart;
		ctl_s1.first_frame = smp_s1.first_frame;
		ctl_s1.last_frame  = smp_s1.last_frame;
		ctl_s1.vchk        = smp_s1.selected && chk_vel_q;
	end

	// ------------------------------------------------------------------
	// Stage 2: times frame rate, limits times ratio
	// ------------------------------------------------------------------
	logic signed [32:0] d1_s2, d2_s2;
	logic signed [31:0] lv_s2, uv_s2;
	jlrm_pkg::ctl_t     ctl_s2;
	logic signed [10:0] rate_s;
	logic signed [7:0]  ratio_s;
	logic signed [43:0] num1, num2;
	logic signed [39:0] hi, lo;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			d1_s2   <= d1;
			d2_s2   <= d2;
			lv_s2   <= smp_s1.lower_velocity_limit;
			uv_s2   <= smp_s1.upper_velocity_limit;
			ctl_s2  <= ctl_s1;
			slot_s2 <= slot_s1;
			wr_a_s2 <= wr_a;
		end
	end

	assign rate_s  = {1'b0, rate_q};
	assign ratio_s = {1'b0, ratio_q};
	assign num1    = d1_s2 * rate_s;
	assign num2    = d2_s2 * rate_s;
	assign hi      = uv_s2 * ratio_s;
	assign lo      = lv_s2 * ratio_s;

	// ------------------------------------------------------------------
	// Stage 3: twice-velocity times 50 for the percent compare, reported values,
	// velocity run bit read (memory B)
	// ------------------------------------------------------------------
	logic               v_s3;
	logic [AW-1:0]      slot_s3;
	logic signed [43:0] num1_s3, num2_s3;
	logic signed [39:0] hi_s3, lo_s3;
	jlrm_pkg::ctl_t     ctl_s3;
	logic signed [49:0] n1, n2, lhs1, lhs2;
	logic [31:0]        pv, fv;

	always_ff @(posedge clk) begin
		if (v_s2) begin
			num1_s3 <= num1;
			num2_s3 <= num2;
			hi_s3   <= hi;
			lo_s3   <= lo;
			ctl_s3  <= ctl_s2;
			slot_s3 <= slot_s2;
		end
	end

	always_comb begin
		n1   = {{6{num1_s3[43]}}, num1_s3};
		n2   = {{6{num2_s3[43]}}, num2_s3};
		lhs1 = (n1 <<< 5) + (n1 <<< 4) + (n1 <<< 1);
		lhs2 = (n2 <<< 5) + (n2 <<< 4) + (n2 <<< 1);
		pv   = ctl_s3.first_frame ? 32'd0 : jlrm_pkg::sat_half(num1_s3);
		fv   = ctl_s3.last_frame ? jlrm_pkg::sat_half(num2_s3) : 32'd0;
	end

	// ------------------------------------------------------------------
	// Stage 4: velocity compare, velocity run bit update, result word
	// ------------------------------------------------------------------
	logic              mem_b [JOINTS];
	logic [JOINTS-1:0] vld_b_q;

	logic               v_s4;
	logic [AW-1:0]      slot_s4;
	logic signed [49:0] lhs1_s4, lhs2_s4;
	logic signed [39:0] hi_s4, lo_s4;
	logic [31:0]        pv_s4, fv_s4;
	jlrm_pkg::ctl_t     ctl_s4;
	logic               rd_b_s4, rdv_b_s4;

	logic               v_s5;
	logic [AW-1:0]      slot_s5;
	logic               vfl_s5;

	logic signed [49:0] hi50, lo50;
	logic               f1, f2, vfl_old, vf0, vf1, vf2, pv_start, fv_start;
	jlrm_pkg::result_t  res_s4;

	always_ff @(posedge clk) begin
		if (v_s3) begin
			lhs1_s4 <= lhs1;
			lhs2_s4 <= lhs2;
			hi_s4   <= hi_s3;
			lo_s4   <= lo_s3;
			pv_s4   <= pv;
			fv_s4   <= fv;
			ctl_s4  <= ctl_s3;
			slot_s4 <= slot_s3;
			rd_b_s4 <= mem_b[slot_s3];
		end
		if (v_s4) begin
			mem_b[slot_s4] <= vf2;
			slot_s5        <= slot_s4;
			vfl_s5         <= vf2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			rdv_b_s4 <= 1'b0;
			vld_b_q  <= '0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (v_s3) begin
				rdv_b_s4 <= vld_b_q[slot_s3];
			end
			if (v_s4) begin
				vld_b_q[slot_s4] <= 1'b1;
			end
		end
	end

	always_comb begin
		hi50 = {{10{hi_s4[39]}}, hi_s4};
		lo50 = {{10{lo_s4[39]}}, lo_s4};
		f1   = ctl_s4.vchk && ((lhs1_s4 > hi50) || (lhs1_s4 < lo50));
		f2   = ctl_s4.vchk && ((lhs2_s4 > hi50) || (lhs2_s4 < lo50));

		// same-joint word one ahead wrote on the edge of our read
		if (v_s5 && (slot_s5 == slot_s4)) begin
			vfl_old = vfl_s5;
		end else begin
			vfl_old = rdv_b_s4 && rd_b_s4;
		end

		// run bit cleared on a first frame, then prior check, then final check
		vf0      = ctl_s4.first_frame ? 1'b0 : vfl_old;
		pv_start = !ctl_s4.first_frame && f1 && !vf0;
		vf1      = ctl_s4.first_frame ? vf0 : f1;
		fv_start = ctl_s4.last_frame && f2 && !vf1;
		vf2      = ctl_s4.last_frame ? f2 : vf1;

		res_s4.joint_out                  = ctl_s4.joint;
		res_s4.position_fault             = ctl_s4.pos_fault;
		res_s4.position_fault_start       = ctl_s4.pos_start;
		res_s4.prior_velocity_valid       = !ctl_s4.first_frame;
		res_s4.prior_velocity             = pv_s4;
		res_s4.prior_velocity_fault_start = pv_start;
		res_s4.final_velocity             = fv_s4;
		res_s4.final_velocity_fault_start = fv_start;
	end

	// ------------------------------------------------------------------
	// Result queue
	// ------------------------------------------------------------------
	jlrm_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s4),
		.push_data (res_s4),
		.result    (result)
	);

`ifndef ASSERT_OFF
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= jlrm_pkg::OCC_W'(jlrm_pkg::FIFO_DEPTH))
		else $error("credit count beyond queue depth");

	a_inflight_counted: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({v_s1, v_s2, v_s3, v_s4}) <= occ_q)
		else $error("pipeline holds words not covered by credit");

	a_pop_counted: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (occ_q != '0))
		else $error("result offered with no word in flight");

	a_pipe_latency: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##4 v_s4)
		else $error("accepted word did not reach the last stage");
`endif

endmodule

FILE: sv/jlrm_out_fifo.sv
module jlrm_out_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  jlrm_pkg::result_t  push_data,
	jlrm_stream_if.source      result
);

	jlrm_pkg::result_t store_q [jlrm_pkg::FIFO_DEPTH];
	logic [jlrm_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [jlrm_pkg::OCC_W-1:0]   count_q;
	logic                         pop;

	assign result.valid = (count_q != '0);
	assign result.data  = store_q[rd_ptr_q];
	assign pop          = result.valid && result.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	// upstream credit keeps push away from a full queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: bench/jlrm_result_checker.sv
module jlrm_result_checker
	import jlrm_pkg::*;
#(
	parameter int JOINTS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  sample_valid,
	input  logic                  sample_ready,
	input  sample_t               sample_word,
	input  logic                  result_valid,
	input  logic                  result_ready,
	input  result_t               result_word,
	output int                    failures,
	output int                    outstanding
);

	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	// shadow copy of the register file
	longint angle_margin;
	longint slide_margin;
	longint speed_ratio;
	longint frame_rate;
	bit     pos_check;
	bit     vel_check;

	// per-joint history and fault runs
	longint recent_pos [JOINTS];
	longint older_pos [JOINTS];
	bit     recent_was_first [JOINTS];
	bit     pos_run [JOINTS];
	bit     vel_run [JOINTS];

	result_t verdicts [$];
	int      mismatch_count = 0;
	int      pending_count = 0;

	assign failures    = mismatch_count;
	assign outstanding = pending_count;

	// floor of half, clamped to 32 bits
	function automatic logic [31:0] half_velocity(input longint twice);
		longint h;
		h = twice >>> 1;
		if (h > Q_MAX) begin
			h = Q_MAX;
		end else if (h < Q_MIN) begin
			h = Q_MIN;
		end
		return h[31:0];
	endfunction

	// exact compare: v = twice / 2 against limit * ratio / 100, everything times 100
	function automatic bit velocity_breach(input longint twice, input longint lo,
		input longint hi);
		return (twice * 50 > hi * speed_ratio) || (twice * 50 < lo * speed_ratio);
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic check_field(input string field, input longint got, input longint want);
		if (got != want) begin
			report_mismatch($sformatf("%s got %0d, expected %0d", field, got, want));
		end
	endtask

	task automatic judge_sample(input sample_t s);
		int      j;
		longint  q;
		longint  m;
		longint  prior;
		longint  twice;
		bit      breach;
		bit      pos_bad;
		bit      vchk;
		result_t r;
		j     = int'(s.joint_index) % JOINTS;
		q     = longint'($signed(s.position));
		vchk  = s.selected && vel_check;
		r     = '0;
		r.joint_out = s.joint_index;
		if (s.first_frame) begin
			pos_run[j] = 1'b0;
			vel_run[j] = 1'b0;
		end
		pos_bad = 1'b0;
		if (s.selected && pos_check &&
			(s.joint_kind == KIND_ROTATIONAL || s.joint_kind == KIND_SLIDING)) begin
			m = (s.joint_kind == KIND_ROTATIONAL) ? angle_margin : slide_margin;
			pos_bad = (q > longint'($signed(s.upper_limit)) - m) ||
				(q < longint'($signed(s.lower_limit)) + m);
		end
		r.position_fault       = pos_bad;
		r.position_fault_start = pos_bad && !pos_run[j];
		pos_run[j] = pos_bad;
		if (!s.first_frame) begin
			prior  = recent_was_first[j] ? recent_pos[j] : older_pos[j];
			twice  = (q - prior) * frame_rate;
			breach = vchk && velocity_breach(twice, longint'($signed(s.lower_velocity_limit)),
				longint'($signed(s.upper_velocity_limit)));
			r.prior_velocity_valid       = 1'b1;
			r.prior_velocity             = half_velocity(twice);
			r.prior_velocity_fault_start = breach && !vel_run[j];
			vel_run[j] = breach;
		end
		if (s.last_frame) begin
			prior  = s.first_frame ? q : recent_pos[j];
			twice  = (q - prior) * frame_rate;
			breach = vchk && velocity_breach(twice, longint'($signed(s.lower_velocity_limit)),
				longint'($signed(s.upper_velocity_limit)));
			r.final_velocity             = half_velocity(twice);
			r.final_velocity_fault_start = breach && !vel_run[j];
			vel_run[j] = breach;
		end
		older_pos[j]        = recent_pos[j];
		recent_pos[j]       = q;
		recent_was_first[j] = s.first_frame;
		verdicts.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			angle_margin = 0;
			slide_margin = 0;
			speed_ratio  = 100;
			frame_rate   = 100;
			pos_check    = 1'b1;
			vel_check    = 1'b1;
			for (int i = 0; i < JOINTS; i++) begin
				recent_pos[i]       = 0;
				older_pos[i]        = 0;
				recent_was_first[i] = 1'b0;
				pos_run[i]          = 1'b0;
				vel_run[i]          = 1'b0;
			end
			verdicts.delete();
			pending_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ANGLE_MARGIN:       angle_margin = longint'($signed(cfg_wdata[17:0]));
					REG_TRANSLATION_MARGIN: slide_margin = longint'($signed(cfg_wdata[20:0]));
					REG_VELOCITY_RATIO:     speed_ratio  = longint'(cfg_wdata[6:0]);
					REG_FRAME_RATE:         frame_rate   = longint'(cfg_wdata[9:0]);
					REG_CHECK_POSITION:     pos_check    = cfg_wdata[0];
					REG_CHECK_VELOCITY:     vel_check    = cfg_wdata[0];
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (verdicts.size() == 0) begin
					report_mismatch("result word with no word expected");
				end else begin
					want = verdicts.pop_front();
					check_field("joint_out", result_word.joint_out, want.joint_out);
					check_field("position_fault", result_word.position_fault,
						want.position_fault);
					check_field("position_fault_start", result_word.position_fault_start,
						want.position_fault_start);
					check_field("prior_velocity_valid", result_word.prior_velocity_valid,
						want.prior_velocity_valid);
					check_field("prior_velocity", $signed(result_word.prior_velocity),
						$signed(want.prior_velocity));
					check_field("prior_velocity_fault_start",
						result_word.prior_velocity_fault_start,
						want.prior_velocity_fault_start);
					check_field("final_velocity", $signed(result_word.final_velocity),
						$signed(want.final_velocity));
					check_field("final_velocity_fault_start",
						result_word.final_velocity_fault_start,
						want.final_velocity_fault_start);
				end
			end
			if (sample_valid && sample_ready) begin
				judge_sample(sample_word);
			end
			pending_count <= verdicts.size();
		end
	end

endmodule

FILE: bench/testbench.sv
// Top of the bench for the joint limit run monitor.
// This module only makes stimulus and gives the verdict; the checker instance beside
// the block watches both channels and the register port, predicts every result word
// and compares it field by field.
module testbench;
	import jlrm_pkg::*;

	localparam int     PHASES          = 8;
	localparam int     WORDS_PER_PHASE = 235;
	localparam int     HOLD_CYCLES     = 200;
	localparam int     CYCLE_LIMIT     = 300000;
	localparam longint Q_MAX           = 64'sd2147483647;
	localparam longint Q_MIN           = -64'sd2147483648;

	// joint kinds that skip the position check
	localparam logic [1:0] KIND_UNCHECKED = 2'd2;
	localparam logic [1:0] KIND_RESERVED  = 2'd3;

	typedef enum logic [1:0] {RX_RANDOM, RX_STEADY, RX_HOLD} rx_mode_e;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	jlrm_stream_if #(.T(sample_t)) sample_bus ();
	jlrm_stream_if #(.T(result_t)) result_bus ();

	int       failures;
	int       outstanding;
	int       words_sent;
	int       cycles;
	rx_mode_e rx_mode;
	bit       tx_steady;
	bit       written [64];
	longint   cur_rate;

	joint_limit_run_monitor_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sample    (sample_bus),
		.result    (result_bus)
	);

	jlrm_result_checker result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.sample_valid (sample_bus.valid),
		.sample_ready (sample_bus.ready),
		.sample_word  (sample_bus.data),
		.result_valid (result_bus.valid),
		.result_ready (result_bus.ready),
		.result_word  (result_bus.data),
		.failures     (failures),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog, sized well above the slowest honest run (one word per cycle,
	// ~28% idle on each side, one hold, a short drain per phase).
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Result side. Random back-pressure, a no-stall mode, and a one-shot hold whose
	// length is counted here while the sender keeps pushing, so the output
	// queue fills and the block drops its input ready.
	initial begin
		int hold_count;
		hold_count = 0;
		result_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_mode == RX_HOLD && hold_count < HOLD_CYCLES) begin
				result_bus.ready <= 1'b0;
				hold_count++;
			end else if (rx_mode == RX_STEADY) begin
				result_bus.ready <= 1'b1;
			end else begin
				result_bus.ready <= ($urandom_range(99) >= 28);
			end
			if (rx_mode != RX_HOLD) begin
				hold_count = 0;
			end
		end
	end

	function automatic longint fit32(input longint v);
		if (v > Q_MAX) begin
			return Q_MAX;
		end else if (v < Q_MIN) begin
			return Q_MIN;
		end
		return v;
	endfunction

	// Offer one word and hold it until taken. The first word a joint sees after
	// reset always opens a run, so the position history is never read unwritten.
	// Valid stays high on return; the caller either offers again or drops it.
	task automatic offer(input sample_t w);
		if (!written[w.joint_index]) begin
			w.first_frame = 1'b1;
		end
		written[w.joint_index] = 1'b1;
		while (!tx_steady && $urandom_range(99) < 28) begin
			sample_bus.valid <= 1'b0;
			@(posedge clk);
		end
		sample_bus.valid <= 1'b1;
		sample_bus.data  <= w;
		@(posedge clk);
		while (!sample_bus.ready) begin
			@(posedge clk);
		end
		words_sent++;
	endtask

	task automatic directed(input int joint, input longint q, input longint lo,
		input longint hi, input longint vlo, input longint vhi, input logic [1:0] kind,
		input bit sel, input bit first, input bit last);
		sample_t w;
		w.joint_index          = 6'(joint);
		w.position             = 32'(q);
		w.lower_limit          = 32'(lo);
		w.upper_limit          = 32'(hi);
		w.lower_velocity_limit = 32'(vlo);
		w.upper_velocity_limit = 32'(vhi);
		w.joint_kind           = kind;
		w.selected             = sel;
		w.first_frame          = first;
		w.last_frame           = last;
		offer(w);
	endtask

	// A well-formed run: a few joints, a few frames, each joint random-walking
	// around its limits; velocity limits sized from the step so both sides trip.
	task automatic motion();
		int         nj;
		int         nf;
		int         pick;
		int         swap;
		int         hop;
		int         slot [6];
		int         order [6];
		longint     pos [6];
		longint     lo [6];
		longint     hi [6];
		longint     vlo [6];
		longint     vhi [6];
		longint     step [6];
		logic [1:0] kind [6];
		bit         sel [6];
		bit         dup;
		longint     span;
		longint     vmax;
		sample_t    w;
		nj = $urandom_range(1, 6);
		nf = $urandom_range(1, 8);
		for (int k = 0; k < nj; k++) begin
			do begin
				slot[k] = $urandom_range(63);
				dup = 1'b0;
				for (int i = 0; i < k; i++) begin
					if (slot[i] == slot[k]) begin
						dup = 1'b1;
					end
				end
			end while (dup);
			step[k] = longint'(1) << $urandom_range(4, 24);
			pos[k]  = longint'($signed($urandom)) >>> $urandom_range(0, 20);
			span    = step[k] * longint'($urandom_range(1, 10));
			lo[k]   = fit32(pos[k] - span);
			hi[k]   = fit32(pos[k] + span);
			vmax    = step[k] * cur_rate / 2 * longint'($urandom_range(10, 120)) / 100;
			vhi[k]  = fit32(vmax);
			vlo[k]  = fit32(-vmax * longint'($urandom_range(50, 150)) / 100);
			case ($urandom_range(9))
				0, 1, 2, 3: kind[k] = KIND_ROTATIONAL;
				4, 5, 6, 7: kind[k] = KIND_SLIDING;
				8:          kind[k] = KIND_UNCHECKED;
				default:    kind[k] = KIND_RESERVED;
			endcase
			sel[k]   = ($urandom_range(9) != 0);
			order[k] = k;
		end
		for (int f = 0; f < nf; f++) begin
			// joints of one frame come in any order
			for (int k = nj - 1; k > 0; k--) begin
				pick        = $urandom_range(k);
				swap        = order[k];
				order[k]    = order[pick];
				order[pick] = swap;
			end
			for (int k = 0; k < nj; k++) begin
				hop = order[k];
				w.joint_index          = 6'(slot[hop]);
				w.position             = 32'(pos[hop]);
				w.lower_limit          = 32'(lo[hop]);
				w.upper_limit          = 32'(hi[hop]);
				w.lower_velocity_limit = 32'(vlo[hop]);
				w.upper_velocity_limit = 32'(vhi[hop]);
				w.joint_kind           = kind[hop];
				// now and then a joint's selection flips for a single word mid-run
				w.selected             = sel[hop] ^ ($urandom_range(19) == 0);
				w.first_frame          = (f == 0);
				w.last_frame           = (f == nf - 1);
				offer(w);
				pos[hop] = fit32(pos[hop] + longint'($urandom_range(32'(2 * step[hop])))
					- step[hop]);
			end
		end
	endtask

	// Raw words: full-range fields and flags, so runs get broken and restarted.
	task automatic noise();
		sample_t w;
		repeat ($urandom_range(1, 8)) begin
			w.joint_index          = 6'($urandom);
			w.position             = $urandom;
			w.lower_limit          = $urandom;
			w.upper_limit          = $urandom;
			w.lower_velocity_limit = $urandom;
			w.upper_velocity_limit = $urandom;
			w.joint_kind           = 2'($urandom);
			w.selected             = 1'($urandom);
			w.first_frame          = 1'($urandom);
			w.last_frame           = 1'($urandom);
			offer(w);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_W'(value);
		@(posedge clk);
	endtask

	// Stop offering and wait until every predicted word is back, plus the
	// pipeline depth with margin.
	task automatic settle();
		sample_bus.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int     ang;
		int     slide;
		int     ratio;
		int     rate;
		int     pos_on;
		int     vel_on;
		longint target;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_wdata        = '0;
		sample_bus.valid = 1'b0;
		sample_bus.data  = '0;
		rx_mode          = RX_RANDOM;
		tx_steady        = 1'b0;
		words_sent       = 0;
		cur_rate         = 100;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under reset defaults.
		// single-frame run: first and last on one word
		directed(0, 0, -1, 1, -1, 1, KIND_ROTATIONAL, 1, 1, 1);
		// sitting exactly on the upper limit, then full-scale swings that saturate
		directed(1, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, KIND_ROTATIONAL, 1, 1, 0);
		directed(1, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX, KIND_ROTATIONAL, 1, 0, 0);
		directed(1, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, KIND_ROTATIONAL, 1, 0, 1);
		// sliding joint: a run below, still faulty, back inside, a run above
		directed(2, 5, 10, 20, -1000, 1000, KIND_SLIDING, 1, 1, 0);
		directed(2, 6, 10, 20, -1000, 1000, KIND_SLIDING, 1, 0, 0);
		directed(2, 15, 10, 20, -1000, 1000, KIND_SLIDING, 1, 0, 0);
		directed(2, 25, 10, 20, -1000, 1000, KIND_SLIDING, 1, 0, 1);
		// stream carries on after the last frame with no new first frame
		directed(2, 30, 10, 20, -1000, 1000, KIND_SLIDING, 1, 0, 0);
		// kinds without a position check
		directed(3, Q_MAX, 0, 0, 0, 0, KIND_UNCHECKED, 1, 1, 0);
		directed(3, Q_MIN, 0, 0, 0, 0, KIND_RESERVED, 1, 0, 1);
		// not selected: no flags, velocities still reported
		directed(4, 100, 200, 300, 0, 0, KIND_ROTATIONAL, 0, 1, 0);
		directed(4, -100, 200, 300, 0, 0, KIND_ROTATIONAL, 0, 0, 1);
		// top joint index, degenerate limits
		directed(63, -1, -1, -1, 0, 0, KIND_SLIDING, 1, 1, 0);
		directed(63, 0, -1, -1, Q_MIN, Q_MIN, KIND_SLIDING, 1, 0, 0);
		directed(63, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX, KIND_SLIDING, 1, 0, 1);
		directed(63, 1, Q_MAX, Q_MIN, Q_MAX, Q_MIN, KIND_ROTATIONAL, 1, 1, 1);

		// Phases: register settings from the legal extremes out to the full field
		// width (rate and ratio zero among them), then random legal settings.
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph != 0) begin
				case (ph)
					1: begin
						ang = 114688;   slide = 655360;   ratio = 1;   rate = 1000;
						pos_on = 1; vel_on = 1;
					end
					2: begin
						ang = -114688;  slide = -655360;  ratio = 100; rate = 1;
						pos_on = 0; vel_on = 1;
					end
					3: begin
						ang = -131072;  slide = 1048575;  ratio = 127; rate = 1023;
						pos_on = 1; vel_on = 1;
					end
					4: begin
						ang = 131071;   slide = -1048576; ratio = 0;   rate = 0;
						pos_on = 1; vel_on = 1;
					end
					default: begin
						ang    = int'($urandom_range(229376)) - 114688;
						slide  = int'($urandom_range(1310720)) - 655360;
						ratio  = $urandom_range(1, 100);
						rate   = $urandom_range(1, 1000);
						pos_on = (ph != 6);
						vel_on = (ph == 7);
					end
				endcase
				// registers change only with the pipeline empty
				settle();
				write_reg(REG_ANGLE_MARGIN, ang);
				write_reg(REG_TRANSLATION_MARGIN, slide);
				write_reg(REG_VELOCITY_RATIO, ratio);
				write_reg(REG_FRAME_RATE, rate);
				write_reg(REG_CHECK_POSITION, pos_on);
				write_reg(REG_CHECK_VELOCITY, vel_on);
				cfg_we   <= 1'b0;
				cur_rate = rate;
			end
			// last phase runs with no idling on either side
			tx_steady = (ph == 7);
			rx_mode   <= (ph == 7) ? RX_STEADY : (ph == 1) ? RX_HOLD : RX_RANDOM;
			if (ph == 1) begin
				// keep pushing into the held receiver until input ready drops
				target = words_sent + 48;
				while (words_sent < target) begin
					noise();
				end
				rx_mode <= RX_RANDOM;
			end
			target = words_sent + WORDS_PER_PHASE;
			while (words_sent < target) begin
				if ($urandom_range(99) < 75) begin
					motion();
				end else begin
					noise();
				end
			end
		end

		settle();
		repeat (12) @(posedge clk);
		if (failures == 0 && outstanding == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: joint_limit_run_monitor_unit.f
sv/jlrm_pkg.sv
sv/jlrm_stream_if.sv
sv/jlrm_out_fifo.sv
sv/joint_limit_run_monitor_unit.sv
bench/jlrm_result_checker.sv
bench/testbench.sv
